// ===== hw/rtl/lppc_pkg.sv =====
// Shared types, constants and colour conversion for the layer compositor.
package lppc_pkg;

	localparam int PALETTE_WORDS = 512;
	localparam int PAL_AW        = $clog2(PALETTE_WORDS);
	localparam int NUM_LAYERS    = 4;
	localparam int ENTRY_W       = 22;
	localparam int SPRITE_W      = 24;
	localparam int PAL_DW        = 16;
	localparam int COLOUR_W      = 18;
	localparam int EXT_AW        = 16;
	localparam int PRIO_W        = 2;

	localparam int BIT_EMPTY  = 18;
	localparam int BIT_DIRECT = 19;
	localparam int BIT_EXTPAL = 20;
	localparam int BIT_IS3D   = 21;

	localparam logic [PAL_AW-1:0] SPRITE_PAL_OFFSET = PAL_AW'(9'h100);
	localparam logic [EXT_AW-1:0] EXT_SLOT_OFFSET   = EXT_AW'(16384);
	localparam int                EXT_STRIDE_SHIFT  = 13;

	// input tdata offsets
	localparam int IN_DATA_W   = 144;
	localparam int OFS_PADDR   = 0;
	localparam int OFS_PDATA   = OFS_PADDR + PAL_AW;
	localparam int OFS_SPRITE  = OFS_PDATA + PAL_DW;
	localparam int OFS_LAYER0  = OFS_SPRITE + SPRITE_W;
	localparam int OUT_DATA_W  = 40;
	localparam int KIND_W      = 3;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BG0_PRIO  = 3'd0,
		CFG_BG1_PRIO  = 3'd1,
		CFG_BG2_PRIO  = 3'd2,
		CFG_BG3_PRIO  = 3'd3,
		CFG_EXT_SLOT  = 3'd4
	} cfg_idx_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_PALETTE    = 3'd0,
		KIND_DIRECT     = 3'd1,
		KIND_PASS3D     = 3'd2,
		KIND_BG_EXTPAL  = 3'd3,
		KIND_SPR_EXTPAL = 3'd4
	} kind_t;

	localparam logic MODE_WRITE   = 1'b0;
	localparam logic MODE_COMPOSE = 1'b1;

	typedef logic [ENTRY_W-1:0] entry_t;

	typedef struct packed {
		logic [NUM_LAYERS-1:0][PRIO_W-1:0] bg_prio;
		logic [1:0]                        ext_slot;
	} cfg_t;

	typedef struct packed {
		logic                 compose;
		entry_t               win;
		logic                 is_spr;
		logic [PRIO_W-1:0]    layer;
		logic [PAL_AW-1:0]    pal_addr;
		logic [PAL_DW-1:0]    pal_data;
	} s1_t;

	function automatic logic [COLOUR_W-1:0] cvt_565_666(input logic [PAL_DW-1:0] c);
		return {c[14:10], 1'b0, c[9:5], c[15], c[4:0], 1'b0};
	endfunction

endpackage

// ===== hw/rtl/lppc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lppc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/lppc_select.sv =====
// Stage 1: priority resolution between sprite and background entries.
module lppc_select (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic                          in_valid,
	input  logic                          mode,
	input  logic [lppc_pkg::PAL_AW-1:0]   pal_addr,
	input  logic [lppc_pkg::PAL_DW-1:0]   pal_data,
	input  logic [lppc_pkg::SPRITE_W-1:0] sprite_entry,
	input  lppc_pkg::entry_t [lppc_pkg::NUM_LAYERS-1:0] layer_entry,
	input  lppc_pkg::cfg_t                cfg,
	output logic                          valid_s1,
	output lppc_pkg::s1_t                 item_s1
);

	lppc_pkg::s1_t nxt;
	logic          found;

	always_comb begin
		found        = 1'b0;
		nxt.compose  = (mode == lppc_pkg::MODE_COMPOSE);
		nxt.win      = '0;
		nxt.is_spr   = 1'b0;
		nxt.layer    = '0;
		nxt.pal_addr = pal_addr;
		nxt.pal_data = pal_data;
		for (int p = 0; p < 4; p++) begin
			if (!found && !sprite_entry[lppc_pkg::BIT_EMPTY] &&
			    sprite_entry[23:22] == lppc_pkg::PRIO_W'(p)) begin
				found      = 1'b1;
				nxt.win    = sprite_entry[lppc_pkg::ENTRY_W-1:0];
				nxt.is_spr = 1'b1;
			end
			for (int n = 0; n < lppc_pkg::NUM_LAYERS; n++) begin
				if (!found && cfg.bg_prio[n] == lppc_pkg::PRIO_W'(p) &&
				    !layer_entry[n][lppc_pkg::BIT_EMPTY]) begin
					found     = 1'b1;
					nxt.win   = layer_entry[n];
					nxt.layer = lppc_pkg::PRIO_W'(n);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			item_s1 <= nxt;
		end
	end

endmodule

// ===== hw/rtl/lppc_resolve.sv =====
// Stages 2 and 3: palette access, source decode and colour conversion.
module lppc_resolve (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic                          valid_s1,
	input  lppc_pkg::s1_t                 item_s1,
	input  lppc_pkg::cfg_t                cfg,
	input  logic [lppc_pkg::PAL_DW-1:0]   ram_rdata,
	output logic                          ram_we,
	output logic [lppc_pkg::PAL_AW-1:0]   ram_waddr,
	output logic [lppc_pkg::PAL_DW-1:0]   ram_wdata,
	output logic                          ram_re,
	output logic [lppc_pkg::PAL_AW-1:0]   ram_raddr,
	output logic                          valid_s3,
	output logic [lppc_pkg::COLOUR_W-1:0] colour_s3,
	output lppc_pkg::kind_t               kind_s3,
	output logic [lppc_pkg::EXT_AW-1:0]   ext_s3
);

	logic                          valid_s2;
	logic                          use_ram_s2;
	logic                          ram3d_s2;
	logic [lppc_pkg::COLOUR_W-1:0] colour_s2;
	lppc_pkg::kind_t               kind_s2;
	logic [lppc_pkg::EXT_AW-1:0]   ext_s2;

	logic                          n_use_ram;
	logic [lppc_pkg::COLOUR_W-1:0] n_colour;
	lppc_pkg::kind_t               n_kind;
	logic [lppc_pkg::EXT_AW-1:0]   n_ext;
	logic [lppc_pkg::EXT_AW-1:0]   bg_base;
	logic [lppc_pkg::COLOUR_W-1:0] ram_colour;
	lppc_pkg::entry_t              w;

	assign w         = item_s1.win;
	assign ram_we    = advance && valid_s1 && !item_s1.compose;
	assign ram_waddr = item_s1.pal_addr;
	assign ram_wdata = item_s1.pal_data;
	assign ram_re    = advance && valid_s1 && item_s1.compose;
	// sprite offset wraps within the palette
	assign ram_raddr = w[lppc_pkg::PAL_AW-1:0] +
	                   (item_s1.is_spr ? lppc_pkg::SPRITE_PAL_OFFSET : '0);

	always_comb begin
		bg_base = lppc_pkg::EXT_AW'(item_s1.layer) << lppc_pkg::EXT_STRIDE_SHIFT;
		if (!item_s1.layer[1] && cfg.ext_slot[item_s1.layer[0]]) begin
			bg_base = bg_base + lppc_pkg::EXT_SLOT_OFFSET;
		end
		n_use_ram = 1'b0;
		n_colour  = '0;
		n_ext     = '0;
		n_kind    = lppc_pkg::KIND_PALETTE;
		if (w[lppc_pkg::BIT_DIRECT]) begin
			if (w[lppc_pkg::BIT_IS3D]) begin
				n_colour = w[lppc_pkg::COLOUR_W-1:0];
				n_kind   = lppc_pkg::KIND_PASS3D;
			end else begin
				n_colour = lppc_pkg::cvt_565_666(w[lppc_pkg::PAL_DW-1:0]);
				n_kind   = lppc_pkg::KIND_DIRECT;
			end
		end else if (w[lppc_pkg::BIT_EXTPAL]) begin
			if (item_s1.is_spr) begin
				n_ext  = w[lppc_pkg::EXT_AW-1:0];
				n_kind = lppc_pkg::KIND_SPR_EXTPAL;
			end else begin
				n_ext  = w[lppc_pkg::EXT_AW-1:0] + bg_base;
				n_kind = lppc_pkg::KIND_BG_EXTPAL;
			end
		end else begin
			n_use_ram = 1'b1;
			n_kind    = w[lppc_pkg::BIT_IS3D] ? lppc_pkg::KIND_PASS3D : lppc_pkg::KIND_PALETTE;
		end
	end

	assign ram_colour = ram3d_s2 ? lppc_pkg::COLOUR_W'(ram_rdata)
	                             : lppc_pkg::cvt_565_666(ram_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && item_s1.compose;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			use_ram_s2 <= n_use_ram;
			ram3d_s2   <= w[lppc_pkg::BIT_IS3D];
			colour_s2  <= n_colour;
			kind_s2    <= n_kind;
			ext_s2     <= n_ext;
			colour_s3  <= use_ram_s2 ? ram_colour : colour_s2;
			kind_s3    <= kind_s2;
			ext_s3     <= ext_s2;
		end
	end

endmodule

// ===== hw/rtl/layer_priority_pixel_compositor.sv =====
// Top level of the per-pixel layer priority compositor.
//
// Input stream (s_axis): tuser carries the mode, 0 stores a palette word, 1 composes
// one pixel from a sprite entry and four background entries. Output stream
// (m_axis) carries one beat per compose beat and none per palette write.
// Configuration: cfg_we/cfg_index/cfg_data set background priorities (0..3)
// and the extended palette slot select (4); other indexes are ignored.
// Three register stages: priority select, palette read and decode, colour
// conversion into the output register. A compose beat accepted on s_axis passes
// through the select, decode and output registers before it appears on m_axis.
// One beat per cycle is sustained while the receiver does not stall; the palette
// RAM port is used by one beat per cycle, a write or a read.
// Reset clears the pipeline valids and the configuration registers; the palette
// is undefined until written. When the receiver stalls the whole pipeline holds and
// s_axis_tready drops; no beat is lost or repeated.
module layer_priority_pixel_compositor (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// pal_addr, pal_data, sprite_entry, layer0..layer3_entry, zero pad
	input  logic [lppc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// mode
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// pixel_color, ext_address, zero pad
	output logic [lppc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// source_kind
	output logic [lppc_pkg::KIND_W-1:0]      m_axis_tuser,
	input  logic                             cfg_we,
	input  logic [lppc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lppc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	lppc_pkg::cfg_t                           cfg_q;
	logic                                     advance;
	logic                                     valid_s1;
	lppc_pkg::s1_t                            item_s1;
	lppc_pkg::entry_t [lppc_pkg::NUM_LAYERS-1:0] layers;
	logic                                     ram_we, ram_re;
	logic [lppc_pkg::PAL_AW-1:0]              ram_waddr, ram_raddr;
	logic [lppc_pkg::PAL_DW-1:0]              ram_wdata, ram_rdata;
	logic                                     valid_s3;
	logic [lppc_pkg::COLOUR_W-1:0]            colour_s3;
	lppc_pkg::kind_t                          kind_s3;
	logic [lppc_pkg::EXT_AW-1:0]              ext_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lppc_pkg::CFG_BG0_PRIO: cfg_q.bg_prio[0] <= cfg_data;
				lppc_pkg::CFG_BG1_PRIO: cfg_q.bg_prio[1] <= cfg_data;
				lppc_pkg::CFG_BG2_PRIO: cfg_q.bg_prio[2] <= cfg_data;
				lppc_pkg::CFG_BG3_PRIO: cfg_q.bg_prio[3] <= cfg_data;
				lppc_pkg::CFG_EXT_SLOT: cfg_q.ext_slot   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance       = !valid_s3 || m_axis_tready;
	assign s_axis_tready = advance;

	always_comb begin
		for (int n = 0; n < lppc_pkg::NUM_LAYERS; n++) begin
			layers[n] = s_axis_tdata[lppc_pkg::OFS_LAYER0 + n*lppc_pkg::ENTRY_W +:
			                         lppc_pkg::ENTRY_W];
		end
	end

	lppc_select u_select (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.in_valid     (s_axis_tvalid),
		.mode         (s_axis_tuser),
		.pal_addr     (s_axis_tdata[lppc_pkg::OFS_PADDR +: lppc_pkg::PAL_AW]),
		.pal_data     (s_axis_tdata[lppc_pkg::OFS_PDATA +: lppc_pkg::PAL_DW]),
		.sprite_entry (s_axis_tdata[lppc_pkg::OFS_SPRITE +: lppc_pkg::SPRITE_W]),
		.layer_entry  (layers),
		.cfg          (cfg_q),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1)
	);

	lppc_ram #(
		.WIDTH (lppc_pkg::PAL_DW),
		.DEPTH (lppc_pkg::PALETTE_WORDS)
	) u_palette (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lppc_resolve u_resolve (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.cfg       (cfg_q),
		.ram_rdata (ram_rdata),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.valid_s3  (valid_s3),
		.colour_s3 (colour_s3),
		.kind_s3   (kind_s3),
		.ext_s3    (ext_s3)
	);

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = {{(lppc_pkg::OUT_DATA_W - lppc_pkg::COLOUR_W - lppc_pkg::EXT_AW){1'b0}},
	                        ext_s3, colour_s3};
	assign m_axis_tuser  = kind_s3;

endmodule

// ===== hw/rtl/lppc_checker.sv =====
// Port-level checks for the layer compositor, bound to the top level.
module lppc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [lppc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [lppc_pkg::KIND_W-1:0]     m_axis_tuser
);

	logic is_ext;
	assign is_ext = (m_axis_tuser == lppc_pkg::KIND_BG_EXTPAL) ||
	                (m_axis_tuser == lppc_pkg::KIND_SPR_EXTPAL);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output beat changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser <= lppc_pkg::KIND_SPR_EXTPAL)
		else $error("source kind out of range");

	a_ext_colour: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && is_ext |-> m_axis_tdata[lppc_pkg::COLOUR_W-1:0] == '0)
		else $error("colour not zero on extended palette request");

	a_colour_ext: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !is_ext |->
		m_axis_tdata[lppc_pkg::COLOUR_W +: lppc_pkg::EXT_AW] == '0)
		else $error("extended address not zero on colour beat");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		m_axis_tdata[lppc_pkg::OUT_DATA_W-1:lppc_pkg::COLOUR_W + lppc_pkg::EXT_AW] == '0)
		else $error("output pad bits not zero");

endmodule

bind layer_priority_pixel_compositor lppc_checker u_lppc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ===== tb/sv/tb_layer_priority_pixel_compositor.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the layer priority pixel compositor.
module tb_layer_priority_pixel_compositor;
	import lppc_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS   = 50;

	typedef entry_t [NUM_LAYERS-1:0] layer_set_t;

	typedef struct {
		logic [COLOUR_W-1:0] colour;
		kind_t               kind;
		logic [EXT_AW-1:0]   ext_addr;
	} pixel_t;

	logic                    clk            = 1'b0;
	logic                    arst_n         = 1'b0;
	logic                    s_axis_tvalid  = 1'b0;
	logic                    s_axis_tready;
	logic [IN_DATA_W-1:0]    s_axis_tdata   = '0;
	logic                    s_axis_tuser   = MODE_WRITE;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready  = 1'b0;
	logic [OUT_DATA_W-1:0]   m_axis_tdata;
	logic [KIND_W-1:0]       m_axis_tuser;
	logic                    cfg_we         = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index      = CFG_BG0_PRIO;
	logic [CFG_DATA_W-1:0]   cfg_data       = '0;

	logic [PAL_DW-1:0]       palette_mirror [PALETTE_WORDS];
	logic [PRIO_W-1:0]       layer_prio [NUM_LAYERS] = '{default: '0};
	logic [1:0]              slot_sel = '0;
	pixel_t                  expected_pixels [$];

	int                      mismatches    = 0;
	int                      cycles        = 0;
	int                      send_idle_pct = 0;
	int                      recv_idle_pct = 0;
	int                      hold_req      = 0;
	int                      hold_left     = 0;

	layer_priority_pixel_compositor u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: random stalls plus a long hold-off when requested
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic logic [COLOUR_W-1:0] to_666(input logic [PAL_DW-1:0] c);
		return (COLOUR_W'(c[4:0]) << 1) | (COLOUR_W'(c[15]) << 6)
			| (COLOUR_W'(c[9:5]) << 7) | (COLOUR_W'(c[14:10]) << 13);
	endfunction

	function automatic pixel_t compose_pixel(input logic [SPRITE_W-1:0] spr,
			input layer_set_t bg);
		pixel_t               px;
		entry_t               win;
		logic                 is_spr;
		logic                 found;
		int                   layer;
		logic [PAL_AW-1:0]    rd_addr;
		logic [PAL_DW-1:0]    word;
		logic [EXT_AW-1:0]    base;
		win    = '0;
		is_spr = 1'b0;
		found  = 1'b0;
		layer  = 0;
		for (int p = 0; p < 4 && !found; p++) begin
			if (!spr[BIT_EMPTY] && spr[SPRITE_W-1 -: PRIO_W] == p) begin
				win    = spr[ENTRY_W-1:0];
				is_spr = 1'b1;
				found  = 1'b1;
			end else begin
				for (int n = 0; n < NUM_LAYERS && !found; n++) begin
					if (layer_prio[n] == p && !bg[n][BIT_EMPTY]) begin
						win   = bg[n];
						layer = n;
						found = 1'b1;
					end
				end
			end
		end
		px.colour   = '0;
		px.ext_addr = '0;
		if (win[BIT_DIRECT]) begin
			if (win[BIT_IS3D]) begin
				px.colour = win[17:0];
				px.kind   = KIND_PASS3D;
			end else begin
				px.colour = to_666(win[15:0]);
				px.kind   = KIND_DIRECT;
			end
		end else if (win[BIT_EXTPAL]) begin
			if (is_spr) begin
				px.ext_addr = win[15:0];
				px.kind     = KIND_SPR_EXTPAL;
			end else begin
				base = EXT_AW'(layer) << EXT_STRIDE_SHIFT;
				if (layer <= 1 && slot_sel[layer])
					base = base + EXT_SLOT_OFFSET;
				px.ext_addr = win[15:0] + base;
				px.kind     = KIND_BG_EXTPAL;
			end
		end else begin
			rd_addr = win[PAL_AW-1:0] + (is_spr ? SPRITE_PAL_OFFSET : '0);
			word    = palette_mirror[rd_addr];
			if (win[BIT_IS3D]) begin
				px.colour = COLOUR_W'(word);
				px.kind   = KIND_PASS3D;
			end else begin
				px.colour = to_666(word);
				px.kind   = KIND_PALETTE;
			end
		end
		return px;
	endfunction

	always @(posedge clk) begin : check_pixels
		pixel_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_pixels.size() == 0) begin
				$error("unexpected output beat tdata %h tuser %0d", m_axis_tdata, m_axis_tuser);
				mismatches++;
			end else begin
				want = expected_pixels.pop_front();
				if (m_axis_tdata[COLOUR_W-1:0] !== want.colour) begin
					$error("pixel_color expected %h actual %h", want.colour,
						m_axis_tdata[COLOUR_W-1:0]);
					mismatches++;
				end
				if (m_axis_tuser !== want.kind) begin
					$error("source_kind expected %0d actual %0d", want.kind, m_axis_tuser);
					mismatches++;
				end
				if (m_axis_tdata[COLOUR_W +: EXT_AW] !== want.ext_addr) begin
					$error("ext_address expected %h actual %h", want.ext_addr,
						m_axis_tdata[COLOUR_W +: EXT_AW]);
					mismatches++;
				end
			end
		end
	end

	function automatic entry_t bg_entry(input logic [17:0] idx, input logic empty,
			input logic direct, input logic extpal, input logic is3d);
		return {is3d, extpal, direct, empty, idx};
	endfunction

	function automatic logic [SPRITE_W-1:0] spr_entry(input logic [PRIO_W-1:0] prio,
			input logic [17:0] idx, input logic empty, input logic direct,
			input logic extpal, input logic is3d);
		return {prio, bg_entry(idx, empty, direct, extpal, is3d)};
	endfunction

	task automatic send_beat(input logic mode, input logic [PAL_AW-1:0] addr,
			input logic [PAL_DW-1:0] data, input logic [SPRITE_W-1:0] spr,
			input layer_set_t bg);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= IN_DATA_W'({bg[3], bg[2], bg[1], bg[0], spr, data, addr});
		do @(posedge clk); while (!s_axis_tready);
		if (mode == MODE_WRITE)
			palette_mirror[addr] = data;
		else
			expected_pixels.push_back(compose_pixel(spr, bg));
	endtask

	task automatic send_pixel(input logic [SPRITE_W-1:0] spr, input layer_set_t bg);
		send_beat(MODE_COMPOSE, PAL_AW'($urandom), PAL_DW'($urandom), spr, bg);
	endtask

	task automatic send_palette(input logic [PAL_AW-1:0] addr, input logic [PAL_DW-1:0] data);
		send_beat(MODE_WRITE, addr, data, SPRITE_W'($urandom),
			{ENTRY_W'($urandom), ENTRY_W'($urandom), ENTRY_W'($urandom), ENTRY_W'($urandom)});
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx < NUM_LAYERS)
			layer_prio[idx] = val;
		else if (idx == CFG_EXT_SLOT)
			slot_sel = val;
	endtask

	task automatic set_config(input logic [1:0] p0, input logic [1:0] p1, input logic [1:0] p2,
			input logic [1:0] p3, input logic [1:0] slot);
		reg_write(CFG_BG0_PRIO, p0);
		reg_write(CFG_BG1_PRIO, p1);
		reg_write(CFG_BG2_PRIO, p2);
		reg_write(CFG_BG3_PRIO, p3);
		reg_write(CFG_EXT_SLOT, slot);
	endtask

	task automatic test_palette_fill();
		for (int a = 0; a < PALETTE_WORDS; a++)
			send_palette(PAL_AW'(a), PAL_DW'($urandom));
		drain();
	endtask

	task automatic test_directed();
		entry_t     nil;
		entry_t     pal;
		layer_set_t bg;
		nil = bg_entry('0, 1'b1, 1'b0, 1'b0, 1'b0);
		pal = bg_entry(18'h00155, 1'b0, 1'b0, 1'b0, 1'b0);
		set_config(2'd1, 2'd0, 2'd0, 2'd2, 2'b11);
		// nothing wins
		send_pixel(spr_entry(2'd0, '0, 1'b1, 1'b0, 1'b0, 1'b0), {nil, nil, nil, nil});
		// sprite wins: palette with wrap, 3D palette, direct 3D, direct, extpal, direct over extpal
		send_pixel(spr_entry(2'd0, 18'h3FFFF, 1'b0, 1'b0, 1'b0, 1'b0), {pal, pal, pal, pal});
		send_pixel(spr_entry(2'd0, 18'h000FF, 1'b0, 1'b0, 1'b0, 1'b1), {pal, pal, pal, pal});
		send_pixel(spr_entry(2'd0, 18'h3FFFF, 1'b0, 1'b1, 1'b0, 1'b1), {pal, pal, pal, pal});
		send_pixel(spr_entry(2'd0, 18'h2ABCD, 1'b0, 1'b1, 1'b0, 1'b0), {pal, pal, pal, pal});
		send_pixel(spr_entry(2'd0, 18'h3FFFF, 1'b0, 1'b0, 1'b1, 1'b0), {pal, pal, pal, pal});
		send_pixel(spr_entry(2'd0, 18'h12345, 1'b0, 1'b1, 1'b1, 1'b0), {pal, pal, pal, pal});
		// lowest-numbered layer at the best level, then the sprite winning a tie
		send_pixel(spr_entry(2'd1, 18'h00042, 1'b0, 1'b0, 1'b0, 1'b0), {pal, pal, pal, pal});
		send_pixel(spr_entry(2'd1, 18'h00042, 1'b0, 1'b0, 1'b0, 1'b0), {pal, pal, nil, pal});
		send_pixel(spr_entry(2'd1, 18'h00042, 1'b0, 1'b0, 1'b0, 1'b0), {pal, nil, nil, pal});
		// extended palette address per layer, wrapping
		for (int n = 0; n < NUM_LAYERS; n++) begin
			bg    = {nil, nil, nil, nil};
			bg[n] = bg_entry(18'h3FFFF, 1'b0, 1'b0, 1'b1, 1'b0);
			send_pixel(spr_entry(2'd0, '0, 1'b1, 1'b0, 1'b0, 1'b0), bg);
		end
		send_pixel(spr_entry(2'd3, '0, 1'b1, 1'b0, 1'b0, 1'b0),
			{nil, nil, bg_entry(18'h3FFFF, 1'b0, 1'b0, 1'b0, 1'b1), nil});
		send_pixel(spr_entry(2'd3, 18'h00007, 1'b0, 1'b0, 1'b0, 1'b0),
			{bg_entry(18'h3FFFF, 1'b0, 1'b1, 1'b0, 1'b1), nil, nil, nil});
		send_pixel(spr_entry(2'd3, 18'h00007, 1'b0, 1'b0, 1'b0, 1'b0), {nil, nil, nil, nil});
		// palette write followed at once by a read of the same word
		send_palette(9'h1FF, 16'hFFFF);
		send_pixel(spr_entry(2'd0, '0, 1'b1, 1'b0, 1'b0, 1'b0),
			{nil, nil, bg_entry(18'h001FF, 1'b0, 1'b0, 1'b0, 1'b0), nil});
		send_palette(9'h000, 16'h0000);
		send_pixel(spr_entry(2'd0, '0, 1'b1, 1'b0, 1'b0, 1'b0), {nil, nil, nil, nil});
		send_palette(9'h100, 16'h8000);
		send_pixel(spr_entry(2'd2, '0, 1'b0, 1'b0, 1'b0, 1'b0), {nil, nil, nil, nil});
		drain();
	endtask

	task automatic test_unknown_index();
		entry_t     ext;
		layer_set_t bg;
		ext = bg_entry(18'h00123, 1'b0, 1'b0, 1'b1, 1'b0);
		set_config(2'd0, 2'd1, 2'd2, 2'd3, 2'b00);
		for (int i = int'(CFG_EXT_SLOT) + 1; i < (1 << CFG_IDX_W); i++)
			reg_write(CFG_IDX_W'(i), '1);
		for (int n = 0; n < NUM_LAYERS; n++) begin
			bg = {ENTRY_W'($urandom), ENTRY_W'($urandom), ENTRY_W'($urandom), ENTRY_W'($urandom)};
			for (int k = 0; k < NUM_LAYERS; k++)
				bg[k][BIT_EMPTY] = (k != n);
			bg[n] = ext;
			send_pixel(spr_entry(2'd0, '0, 1'b1, 1'b0, 1'b0, 1'b0), bg);
		end
		drain();
	endtask

	task automatic test_random();
		logic [1:0] p [4];
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: p = '{2'd0, 2'd0, 2'd0, 2'd0};
				1: p = '{2'd3, 2'd3, 2'd3, 2'd3};
				2: p = '{2'd0, 2'd1, 2'd2, 2'd3};
				3: p = '{2'd3, 2'd2, 2'd1, 2'd0};
				default: begin
					for (int n = 0; n < 4; n++)
						p[n] = 2'($urandom_range(3));
				end
			endcase
			set_config(p[0], p[1], p[2], p[3], 2'(phase));
			case (phase / 2)
				0: begin
					send_idle_pct = 28;
					recv_idle_pct = 77;
				end
				1: begin
					send_idle_pct = 77;
					recv_idle_pct = 28;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(4) == 0)
					send_palette(PAL_AW'($urandom), PAL_DW'($urandom));
				else
					send_pixel(SPRITE_W'($urandom), {ENTRY_W'($urandom), ENTRY_W'($urandom),
						ENTRY_W'($urandom), ENTRY_W'($urandom)});
			end
			drain();
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req      = 400;
		for (int i = 0; i < 80; i++) begin
			if ($urandom_range(5) == 0)
				send_palette(PAL_AW'($urandom), PAL_DW'($urandom));
			else
				send_pixel(SPRITE_W'($urandom), {ENTRY_W'($urandom), ENTRY_W'($urandom),
					ENTRY_W'($urandom), ENTRY_W'($urandom)});
		end
		drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_palette_fill();
		test_directed();
		test_unknown_index();
		test_random();
		test_backpressure();
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
